// ----- design/bb3_pkg.sv -----
package bb3_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;

  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned HEIGHT_W = 12;
  localparam int unsigned ROW_W    = 13;
  localparam int unsigned ITEMS_W  = 23;
  localparam int unsigned PIX_W    = 24;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned SUM_W    = 12;
  localparam int unsigned NUM_W    = 13;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned RECIP_W  = 20;
  localparam int unsigned RECIP_SH = 20;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM,
    ST_DIV
  } state_t;

  // Reciprocal of twice the neighbor count, scaled by 2**RECIP_SH and rounded up.
  // Exact for every numerator below 2**NUM_W.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    m = '0;
    unique case (cnt)
      4'd1:    m = 20'd524288;
      4'd2:    m = 20'd262144;
      4'd3:    m = 20'd174763;
      4'd4:    m = 20'd131072;
      4'd6:    m = 20'd87382;
      4'd9:    m = 20'd58255;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- design/bb3_line_mem.sv -----
module bb3_line_mem #(
  parameter int unsigned DEPTH = bb3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 2 * bb3_pkg::PIX_W
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/box_blur_3x3.sv -----
// Streaming 3x3 box blur over RGB pixels in raster order. Each result is the rounded-half-up
// mean of the in-frame 3x3 neighborhood, so borders and one-pixel frames are normalized by the
// true neighbor count. The result for pixel q leaves with the transfer of item q+width+1, so
// after a frame of width*height pixels, width+1 drain items (or ignored pixels) flush the rest;
// out_frame_last marks the final pixel and the frame counters then restart. Both earlier rows
// live in one line memory with a registered read, read and rewritten at the column of each
// item. An item is taken only when the last is through; one with no result passes the
// line memory read and the window update and write-back; one with a result also passes
// the neighborhood sum and the reciprocal multiply, held while an unaccepted earlier result
// waits. The line memory is not cleared at reset; a register write restarts frame counters.
module box_blur_3x3 #(
  parameter int unsigned MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [bb3_pkg::CH_W-1:0]    in_red,
  input  logic [bb3_pkg::CH_W-1:0]    in_green,
  input  logic [bb3_pkg::CH_W-1:0]    in_blue,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bb3_pkg::CH_W-1:0]    out_red,
  output logic [bb3_pkg::CH_W-1:0]    out_green,
  output logic [bb3_pkg::CH_W-1:0]    out_blue,
  output logic                        out_frame_last,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bb3_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [bb3_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [bb3_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int unsigned AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CMPW = ((AW > bb3_pkg::WIDTH_W) ? AW : bb3_pkg::WIDTH_W) + 1;
  localparam int unsigned PW   = bb3_pkg::PIX_W;
  localparam int unsigned CW   = bb3_pkg::CH_W;
  localparam int unsigned NW   = bb3_pkg::ITEMS_W;
  localparam int unsigned RW   = bb3_pkg::ROW_W;
  localparam int unsigned SW   = bb3_pkg::SUM_W;
  localparam int unsigned XW   = bb3_pkg::NUM_W;
  localparam int unsigned KW   = bb3_pkg::CNT_W;
  localparam int unsigned MW   = bb3_pkg::RECIP_W;
  localparam int unsigned PRW  = XW + MW;

  // Configuration registers.
  logic [bb3_pkg::WIDTH_W-1:0]  frame_width_r;
  logic [bb3_pkg::HEIGHT_W-1:0] frame_height_r;
  logic                         cfg_wr;
  logic [bb3_pkg::WIDTH_W-1:0]  ew;
  logic [bb3_pkg::HEIGHT_W-1:0] eh;
  logic [NW-1:0]                total_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bb3_pkg::WIDTH_RST;
      frame_height_r <= bb3_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        bb3_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[bb3_pkg::WIDTH_W-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[bb3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[2])
      bb3_pkg::REG_FRAME_WIDTH:
        cfg_prdata = {{(bb3_pkg::CFG_DW-bb3_pkg::WIDTH_W){1'b0}}, frame_width_r};
      bb3_pkg::REG_FRAME_HEIGHT:
        cfg_prdata = {{(bb3_pkg::CFG_DW-bb3_pkg::HEIGHT_W){1'b0}}, frame_height_r};
      default: cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (frame_width_r == '0) begin
      ew = bb3_pkg::WIDTH_W'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      ew = bb3_pkg::WIDTH_W'(MAX_WIDTH);
    end else begin
      ew = frame_width_r;
    end
    eh = (frame_height_r == '0) ? bb3_pkg::HEIGHT_W'(1) : frame_height_r;
  end

  always_ff @(posedge clk) begin
    total_r <= NW'(ew) * NW'(eh);
  end

  // Control.
  bb3_pkg::state_t state_r, state_nxt;
  logic            in_xfer;
  logic            produce_r;
  logic            out_load;
  logic            produce;
  logic            last_hit;

  assign in_xfer = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bb3_pkg::ST_IDLE:  if (in_xfer) state_nxt = bb3_pkg::ST_SHIFT;
      bb3_pkg::ST_SHIFT: state_nxt = produce ? bb3_pkg::ST_SUM : bb3_pkg::ST_IDLE;
      bb3_pkg::ST_SUM:   state_nxt = bb3_pkg::ST_DIV;
      bb3_pkg::ST_DIV:   if (!out_valid || out_ready) state_nxt = bb3_pkg::ST_IDLE;
      default:           state_nxt = bb3_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      bb3_pkg::ST_IDLE:  in_ready = 1'b1;
      bb3_pkg::ST_SHIFT: ;
      bb3_pkg::ST_SUM:   ;
      bb3_pkg::ST_DIV:   out_load = produce_r && (!out_valid || out_ready);
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bb3_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Frame counters.
  logic [AW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [NW-1:0] n_r;
  logic [AW-1:0] col_eff;
  logic          do_shift;

  assign col_eff  = ({{(CMPW-AW){1'b0}}, col_r} >= CMPW'(ew)) ? '0 : col_r;
  assign do_shift = (state_r == bb3_pkg::ST_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      n_r   <= '0;
    end else if (cfg_wr || (do_shift && last_hit)) begin
      col_r <= '0;
      row_r <= '0;
      n_r   <= '0;
    end else if (do_shift) begin
      n_r <= n_r + NW'(1);
      if (CMPW'(col_eff) + CMPW'(1) >= CMPW'(ew)) begin
        col_r <= '0;
        row_r <= row_r + RW'(1);
      end else begin
        col_r <= col_eff + AW'(1);
      end
    end
  end

  // Captured input item.
  logic [PW-1:0] pix_in_r;
  logic          action_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix_in_r <= {in_red, in_green, in_blue};
      action_r <= in_action;
    end
  end

  // Line memory: upper half holds two rows back, lower half one row back.
  logic [2*PW-1:0] rd_data;
  logic [PW-1:0]   above2;
  logic [PW-1:0]   above1;
  logic [PW-1:0]   pix;

  assign above2 = rd_data[2*PW-1:PW];
  assign above1 = rd_data[PW-1:0];
  assign pix    = (action_r == bb3_pkg::ACT_DRAIN || n_r >= total_r) ? '0 : pix_in_r;

  bb3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (2 * PW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (col_eff),
    .rd_data (rd_data),
    .wr_en   (do_shift),
    .wr_addr (col_eff),
    .wr_data ({above1, pix})
  );

  // Window and border masks of the pixel whose result is due.
  logic [PW-1:0]        win_r [9];
  logic [2:0]           row_ok_r;
  logic [2:0]           col_ok_r;
  logic                 last_r;
  logic [RW-1:0]        qr;
  logic [CMPW-1:0]      qc;
  logic [2:0]           row_ok;
  logic [2:0]           col_ok;

  assign produce  = {1'b0, n_r} >= ({{(NW+1-bb3_pkg::WIDTH_W){1'b0}}, ew} + (NW+1)'(1));
  assign last_hit = produce && ({1'b0, n_r} >= ({1'b0, total_r} + (NW+1)'(ew)));

  always_comb begin
    if (col_eff == '0) begin
      qc = CMPW'(ew) - CMPW'(1);
      qr = (row_r >= RW'(2)) ? row_r - RW'(2) : '0;
    end else begin
      qc = CMPW'(col_eff) - CMPW'(1);
      qr = (row_r >= RW'(1)) ? row_r - RW'(1) : '0;
    end
    row_ok = {(RW + 1)'(qr) + (RW + 1)'(1) < (RW + 1)'(eh), 1'b1, qr != '0};
    col_ok = {qc + CMPW'(1) < CMPW'(ew), 1'b1, qc != '0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (do_shift) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= above2;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= above1;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      produce_r <= 1'b0;
    end else if (do_shift) begin
      produce_r <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (do_shift) begin
      row_ok_r <= row_ok;
      col_ok_r <= col_ok;
      last_r   <= last_hit;
    end
  end

  // Neighborhood sums and count.
  logic [SW-1:0] sum_r, sum_g, sum_b;
  logic [KW-1:0] cnt;
  logic [XW-1:0] num_r [3];
  logic [KW-1:0] cnt_r;

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        if (row_ok_r[y] && col_ok_r[x]) begin
          sum_r = sum_r + SW'(win_r[y*3+x][3*CW-1:2*CW]);
          sum_g = sum_g + SW'(win_r[y*3+x][2*CW-1:CW]);
          sum_b = sum_b + SW'(win_r[y*3+x][CW-1:0]);
        end
      end
    end
    cnt = (KW'(1) + KW'(row_ok_r[0]) + KW'(row_ok_r[2]))
        * (KW'(1) + KW'(col_ok_r[0]) + KW'(col_ok_r[2]));
  end

  always_ff @(posedge clk) begin
    if (state_r == bb3_pkg::ST_SUM) begin
      num_r[0] <= {sum_r, 1'b0} + XW'(cnt);
      num_r[1] <= {sum_g, 1'b0} + XW'(cnt);
      num_r[2] <= {sum_b, 1'b0} + XW'(cnt);
      cnt_r    <= cnt;
    end
  end

  // Division by twice the count through a reciprocal multiply.
  logic [MW-1:0]  recip_m;
  logic [PRW-1:0] prod [3];

  assign recip_m = bb3_pkg::recip(cnt_r);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PRW'(num_r[c]) * PRW'(recip_m);
    end
  end

  // Output register.
  logic          out_valid_r;
  logic [CW-1:0] out_red_r, out_green_r, out_blue_r;
  logic          out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r   <= prod[0][bb3_pkg::RECIP_SH+CW-1:bb3_pkg::RECIP_SH];
      out_green_r <= prod[1][bb3_pkg::RECIP_SH+CW-1:bb3_pkg::RECIP_SH];
      out_blue_r  <= prod[2][bb3_pkg::RECIP_SH+CW-1:bb3_pkg::RECIP_SH];
      out_last_r  <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_frame_last = out_last_r;

  // The division stage only ever sees a neighbor count that a clipped 3x3 window can have.
  a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bb3_pkg::ST_DIV) |->
      (cnt_r == 4'd1 || cnt_r == 4'd2 || cnt_r == 4'd3 ||
       cnt_r == 4'd4 || cnt_r == 4'd6 || cnt_r == 4'd9))
    else $error("illegal neighbor count at the division stage");

  // The last pixel of a frame restarts the frame counters.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (do_shift && last_hit) |=> (n_r == '0 && col_r == '0 && row_r == '0))
    else $error("frame counters not restarted after the last pixel");

  // A result is loaded only when the output register is free or being emptied.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  // A new item enters only after the previous one has left the shift stage.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == bb3_pkg::ST_SHIFT && !in_ready))
    else $error("item accepted while another is in flight");

endmodule

// ----- tb/box_blur_3x3_test.sv -----
module box_blur_3x3_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CH_W     = bb3_pkg::CH_W;
  localparam int unsigned PIX_W    = bb3_pkg::PIX_W;
  localparam int unsigned WIDTH_W  = bb3_pkg::WIDTH_W;
  localparam int unsigned HEIGHT_W = bb3_pkg::HEIGHT_W;
  localparam int unsigned CFG_AW   = bb3_pkg::CFG_AW;
  localparam int unsigned CFG_DW   = bb3_pkg::CFG_DW;

  localparam logic REG_FRAME_WIDTH  = bb3_pkg::REG_FRAME_WIDTH;
  localparam logic REG_FRAME_HEIGHT = bb3_pkg::REG_FRAME_HEIGHT;
  localparam logic ACT_PIXEL        = bb3_pkg::ACT_PIXEL;
  localparam logic ACT_DRAIN        = bb3_pkg::ACT_DRAIN;

  localparam int unsigned MAX_W = bb3_pkg::MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1630;
  localparam int WIDE_RESULTS = 64;
  localparam int LATENCY_PAD = 16;
  localparam int PLAN_ROWS = 30;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } blur_px_t;

  typedef enum logic [1:0] {
    STEP_WRITE,
    STEP_ITEM,
    STEP_CHECK
  } step_kind_t;

  typedef struct packed {
    step_kind_t      kind;
    logic            idx;
    logic [11:0]     value;
    logic            act;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    blur_px_t        want;
  } plan_row_t;

  localparam blur_px_t NO_PX = '0;

  // Rows of kind STEP_CHECK carry the result that their transfer pushes out.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{STEP_WRITE, REG_FRAME_WIDTH,  12'd1,    ACT_PIXEL, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_WRITE, REG_FRAME_HEIGHT, 12'd1,    ACT_PIXEL, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd255, 8'd0,   8'd128, NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_DRAIN, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_CHECK, REG_FRAME_WIDTH,  12'd0,    ACT_DRAIN, 8'd0,   8'd0,   8'd0,
      '{8'd255, 8'd0, 8'd128, 1'b1}},
    '{STEP_WRITE, REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_WRITE, REG_FRAME_HEIGHT, 12'd0,    ACT_PIXEL, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd0,   8'd255, 8'd1,   NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd77,  8'd77,  8'd77,  NO_PX},
    '{STEP_CHECK, REG_FRAME_WIDTH,  12'd0,    ACT_DRAIN, 8'd0,   8'd0,   8'd0,
      '{8'd0, 8'd255, 8'd1, 1'b1}},
    '{STEP_WRITE, REG_FRAME_WIDTH,  12'd2,    ACT_PIXEL, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_WRITE, REG_FRAME_HEIGHT, 12'd2,    ACT_PIXEL, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd255, 8'd255, 8'd255, NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd255, 8'd255, 8'd255, NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd255, 8'd255, 8'd255, NO_PX},
    '{STEP_CHECK, REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd255, 8'd255, 8'd255,
      '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{STEP_CHECK, REG_FRAME_WIDTH,  12'd0,    ACT_DRAIN, 8'd0,   8'd0,   8'd0,
      '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{STEP_CHECK, REG_FRAME_WIDTH,  12'd0,    ACT_DRAIN, 8'd0,   8'd0,   8'd0,
      '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{STEP_CHECK, REG_FRAME_WIDTH,  12'd0,    ACT_DRAIN, 8'd0,   8'd0,   8'd0,
      '{8'd255, 8'd255, 8'd255, 1'b1}},
    '{STEP_WRITE, REG_FRAME_WIDTH,  12'd2047, ACT_PIXEL, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_WRITE, REG_FRAME_HEIGHT, 12'd1,    ACT_PIXEL, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd1,   8'd2,   8'd3,   NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_DRAIN, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_WRITE, REG_FRAME_WIDTH,  12'd2,    ACT_PIXEL, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_WRITE, REG_FRAME_HEIGHT, 12'd1,    ACT_PIXEL, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd1,   8'd0,   8'd2,   NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd0,   8'd0,   8'd1,   NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd9,   8'd9,   8'd9,   NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_DRAIN, 8'd0,   8'd0,   8'd0,   NO_PX},
    '{STEP_ITEM,  REG_FRAME_WIDTH,  12'd0,    ACT_PIXEL, 8'd200, 8'd200, 8'd200, NO_PX}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_action = ACT_PIXEL;
  logic [CH_W-1:0]   in_red = '0;
  logic [CH_W-1:0]   in_green = '0;
  logic [CH_W-1:0]   in_blue = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CH_W-1:0]   out_red;
  logic [CH_W-1:0]   out_green;
  logic [CH_W-1:0]   out_blue;
  logic              out_frame_last;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  logic [PIX_W-1:0]    line_old [MAX_W];
  logic [PIX_W-1:0]    line_new [MAX_W];
  logic [PIX_W-1:0]    win_px [9];
  int unsigned         col_at;
  int unsigned         row_at;
  int unsigned         seen_count;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;

  blur_px_t pending_px [$];
  blur_px_t got_px;
  int       fails = 0;
  bit       calm = 1'b0;
  int       stall_left = 0;

  box_blur_3x3 #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_frame_last(out_frame_last),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic int idle_span();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic bit blur_predict(input logic act, input logic [CH_W-1:0] r,
                                      input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                                      output blur_px_t res);
    int unsigned w, h, total, c, rw, n, qc, qr, cnt, sum_r, sum_g, sum_b;
    int y, x;
    logic [PIX_W-1:0] fresh [3];
    logic [PIX_W-1:0] p;
    bit last;
    bit made;
    w = eff_width();
    h = eff_height();
    total = w * h;
    c = col_at;
    rw = row_at;
    n = seen_count;
    last = 1'b0;
    made = 1'b0;
    res = '0;
    if (c >= w) c = 0;
    fresh[0] = line_old[c];
    fresh[1] = line_new[c];
    fresh[2] = (act == ACT_PIXEL && n < total) ? {r, g, b} : '0;
    line_old[c] = fresh[1];
    line_new[c] = fresh[2];
    for (y = 0; y < 3; y++) begin
      win_px[y*3] = win_px[y*3+1];
      win_px[y*3+1] = win_px[y*3+2];
      win_px[y*3+2] = fresh[y];
    end
    if (n >= w + 1) begin
      if (c == 0) begin
        qc = w - 1;
        qr = (rw >= 2) ? rw - 2 : 0;
      end else begin
        qc = c - 1;
        qr = (rw >= 1) ? rw - 1 : 0;
      end
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      cnt = 0;
      for (y = 0; y < 3; y++) begin
        if (!(y == 0 && qr == 0) && !(y == 2 && qr + 1 >= h)) begin
          for (x = 0; x < 3; x++) begin
            if (!(x == 0 && qc == 0) && !(x == 2 && qc + 1 >= w)) begin
              p = win_px[y*3+x];
              sum_r += p[23:16];
              sum_g += p[15:8];
              sum_b += p[7:0];
              cnt++;
            end
          end
        end
      end
      res.red = 8'((2 * sum_r + cnt) / (2 * cnt));
      res.green = 8'((2 * sum_g + cnt) / (2 * cnt));
      res.blue = 8'((2 * sum_b + cnt) / (2 * cnt));
      last = (n - w >= total);
      res.last = last;
      made = 1'b1;
    end
    if (last) begin
      col_at = 0;
      row_at = 0;
      seen_count = 0;
    end else begin
      seen_count = n + 1;
      c++;
      if (c >= w) begin
        c = 0;
        rw++;
      end
      col_at = c;
      row_at = rw;
    end
    return made;
  endfunction

  task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = value[WIDTH_W-1:0];
    else height_reg = value[HEIGHT_W-1:0];
    col_at = 0;
    row_at = 0;
    seen_count = 0;
  endtask

  task automatic send_item(input logic act, input logic [CH_W-1:0] r,
                           input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                           input bit typed, input blur_px_t typed_px);
    blur_px_t calc;
    bit made;
    int gap;
    made = blur_predict(act, r, g, b, calc);
    if (typed) pending_px.push_back(typed_px);
    else if (made) pending_px.push_back(calc);
    gap = idle_span();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= act;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= idle_span();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_px.size() == 0) begin
        $error("result transfer with no pixel pending");
        fails++;
      end else begin
        got_px = pending_px.pop_front();
        if (out_red !== got_px.red) begin
          $error("out_red: expected %0d, actual %0d", got_px.red, out_red);
          fails++;
        end
        if (out_green !== got_px.green) begin
          $error("out_green: expected %0d, actual %0d", got_px.green, out_green);
          fails++;
        end
        if (out_blue !== got_px.blue) begin
          $error("out_blue: expected %0d, actual %0d", got_px.blue, out_blue);
          fails++;
        end
        if (out_frame_last !== got_px.last) begin
          $error("out_frame_last: expected %0d, actual %0d", got_px.last, out_frame_last);
          fails++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int sent, phase, frames, span, pick, f, i, k;
    int unsigned ew, eh;
    bit big, cut_short;
    logic act;
    plan_row_t row;
    for (k = 0; k < MAX_W; k++) begin
      line_old[k] = '0;
      line_new[k] = '0;
    end
    for (k = 0; k < 9; k++) win_px[k] = '0;
    col_at = 0;
    row_at = 0;
    seen_count = 0;
    width_reg = bb3_pkg::WIDTH_RST;
    height_reg = bb3_pkg::HEIGHT_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < PLAN_ROWS; k++) begin
      row = PLAN[k];
      case (row.kind)
        STEP_WRITE: begin
          wait_idle();
          write_reg(row.idx, CFG_DW'(row.value));
        end
        STEP_ITEM: send_item(row.act, row.red, row.green, row.blue, 1'b0, NO_PX);
        default: send_item(row.act, row.red, row.green, row.blue, 1'b1, row.want);
      endcase
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      calm = ($urandom_range(0, 4) == 0);
      cut_short = ($urandom_range(0, 4) == 0);
      frames = $urandom_range(1, 3);
      big = 1'b0;
      if (phase == 0) begin
        write_reg(REG_FRAME_WIDTH, CFG_DW'(MAX_W));
        write_reg(REG_FRAME_HEIGHT, 1);
        big = 1'b1;
        cut_short = 1'b0;
        frames = 1;
      end else if (phase == 1) begin
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 4095);
        big = 1'b1;
        cut_short = 1'b1;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, 19);
          write_reg(REG_FRAME_WIDTH, (pick == 0) ? 0 :
                    (pick == 1) ? $urandom_range(9, 40) : $urandom_range(1, 8));
        end
        if ($urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, 19);
          write_reg(REG_FRAME_HEIGHT, (pick == 0) ? 0 :
                    (pick == 1) ? $urandom_range(9, 4095) : $urandom_range(1, 8));
        end
      end
      ew = eff_width();
      eh = eff_height();
      if (!big && ew * eh > 400) cut_short = 1'b1;
      for (f = 0; f < frames; f++) begin
        span = ew * eh + ew + 1;
        if (cut_short) span = $urandom_range(1, (span > 64) ? 64 : span - 1);
        if (phase == 0) span = ew + 1 + WIDE_RESULTS;
        for (i = 0; i < span; i++) begin
          if (sent >= RANDOM_ITEMS) break;
          if (i < ew * eh) act = ($urandom_range(0, 19) == 0) ? ACT_DRAIN : ACT_PIXEL;
          else act = $urandom_range(0, 1) ? ACT_DRAIN : ACT_PIXEL;
          send_item(act, CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                    CH_W'($urandom_range(0, 255)), 1'b0, NO_PX);
          sent++;
        end
        if (cut_short || sent >= RANDOM_ITEMS) break;
      end
      phase++;
    end

    calm = 1'b0;
    wait_idle();
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
